[hw/rtl/dtd_pkg.sv]
// Package for the dictionary token decoder: sequencer and phase types,
// token and status codes, register map constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dtd_pkg;

    localparam int ENTRY_W    = 10;
    localparam int ENTRY_SPAN = 1 << ENTRY_W;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_MODEL_HASH = 1'b0;

    localparam logic [7:0] TOK_IDX1 = 8'd252;
    localparam logic [7:0] TOK_IDX2 = 8'd253;
    localparam logic [7:0] TOK_IDX3 = 8'd254;

    localparam logic [1:0] STAT_DATA  = 2'd0;
    localparam logic [1:0] STAT_HASH  = 2'd1;
    localparam logic [1:0] STAT_THREE = 2'd2;
    localparam logic [1:0] STAT_RANGE = 2'd3;

    localparam logic [6:0] HASH_BYTES = 7'd4;

    typedef enum logic [2:0] {
        SQ_CLEAR,
        SQ_IDLE,
        SQ_CHECK,
        SQ_LEN,
        SQ_EXP
    } t_seq_state;

    typedef enum logic [2:0] {
        PH_HASH,
        PH_TOKEN,
        PH_LITERAL,
        PH_IDX1,
        PH_IDX2,
        PH_IDX4
    } t_phase;

endpackage

`default_nettype wire

[hw/rtl/dtd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dtd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/dictionary_token_decoder.sv]
// Top level of the dictionary token decoder: stream parser, fragment
// expansion sequencer, APB register. Uses dtd_pkg and dtd_ram.
//
// channel  | dir | handshake                     | payload
// ---------+-----+-------------------------------+--------------------------------
// in       | in  | i_in_valid / o_in_stall       | action, stream_byte, entry, ...
// out      | out | o_out_valid / i_out_stall     | out_byte, last, status
// apb      | in  | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// Header, literal-count, literal, index and dictionary bytes are taken in SQ_IDLE while the output is free.
// A fragment expansion holds the input through the range check, the length memory
// read, one byte a cycle from the fragment byte memory read port while the output
// does not stall, the final transfer and a closing step in SQ_EXP.
// Output stalls back up into the expansion and into the input stall.
// After reset a clearing pass zeroes all min(NUM_FRAGMENTS, 1024) length memory
// entries; no item is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module dictionary_token_decoder #(
    parameter int NUM_FRAGMENTS    = 1024,
    parameter int MAX_FRAGMENT_LEN = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_action,
    input  wire logic [7:0]                  i_stream_byte,
    input  wire logic [dtd_pkg::ENTRY_W-1:0] i_entry,
    input  wire logic [4:0]                  i_position,
    input  wire logic [7:0]                  i_entry_byte,
    input  wire logic [5:0]                  i_entry_length,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [7:0]                       o_out_byte,
    output logic                             o_last,
    output logic [1:0]                       o_status,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dtd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [dtd_pkg::PDATA_W-1:0] pwdata,
    output logic      [dtd_pkg::PDATA_W-1:0] prdata,
    output logic                             pready
);

    import dtd_pkg::*;

    localparam int FRAG_DEPTH = (NUM_FRAGMENTS < ENTRY_SPAN) ? NUM_FRAGMENTS : ENTRY_SPAN;
    localparam int FIDX_W     = $clog2(FRAG_DEPTH);
    localparam int LEN_W      = $clog2(MAX_FRAGMENT_LEN + 1);
    localparam int BYTE_DEPTH = FRAG_DEPTH * MAX_FRAGMENT_LEN;
    localparam int BADDR_W    = (BYTE_DEPTH > 1) ? $clog2(BYTE_DEPTH) : 1;

    t_seq_state          r_seq, n_seq;
    t_phase              r_phase, n_phase;
    logic [6:0]          r_count, n_count;
    logic [31:0]         r_acc, n_acc;
    logic                r_halted, n_halted;
    logic [31:0]         r_hash;
    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_out_byte, n_out_byte;
    logic                r_out_last, n_out_last;
    logic [1:0]          r_out_status, n_out_status;
    logic [31:0]         r_idx, n_idx;
    logic                r_store, n_store;
    logic [BADDR_W-1:0]  r_baddr, n_baddr;
    logic [LEN_W-1:0]    r_remaining, n_remaining;
    logic                r_pend, n_pend;
    logic                r_pend_last, n_pend_last;
    logic [FIDX_W-1:0]   r_clr, n_clr;

    logic               in_accept, stream_go, dict_go, entry_ok, pos_ok;
    logic               out_free, move, issue, range_err, start_exp;
    logic [6:0]         len7;
    logic [LEN_W-1:0]   wlen;
    logic [31:0]        shifted_acc;
    logic               len_we;
    logic [FIDX_W-1:0]  len_waddr;
    logic [LEN_W-1:0]   len_wdata;
    logic               len_re;
    logic [LEN_W-1:0]   len_rdata;
    logic               byte_we;
    logic [BADDR_W-1:0] byte_waddr;
    logic [7:0]         byte_rdata;
    logic               cfg_wr;

    // Handshakes
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_seq != SQ_IDLE) || !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign stream_go  = in_accept && !i_action && !r_halted;
    assign entry_ok   = 32'(i_entry) < 32'(FRAG_DEPTH);
    assign pos_ok     = 32'(i_position) < 32'(MAX_FRAGMENT_LEN);
    assign dict_go    = in_accept && i_action && entry_ok;

    assign len7 = {1'b0, i_entry_length};
    assign wlen = (len7 > 7'(MAX_FRAGMENT_LEN)) ? LEN_W'(MAX_FRAGMENT_LEN) : LEN_W'(len7);

    // Dictionary memories
    assign len_we    = (r_seq == SQ_CLEAR) || dict_go;
    assign len_waddr = (r_seq == SQ_CLEAR) ? r_clr : i_entry[FIDX_W-1:0];
    assign len_wdata = (r_seq == SQ_CLEAR) ? '0 : wlen;
    assign range_err = r_idx >= 32'(NUM_FRAGMENTS);
    assign len_re    = (r_seq == SQ_CHECK) && !range_err;

    assign byte_we    = dict_go && pos_ok;
    assign byte_waddr = BADDR_W'(32'(i_entry) * 32'(MAX_FRAGMENT_LEN) + 32'(i_position));

    assign move  = r_pend && out_free;
    assign issue = (r_seq == SQ_EXP) && (r_remaining != '0) && (!r_pend || move);

    dtd_ram #(
        .WIDTH (LEN_W),
        .DEPTH (FRAG_DEPTH)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_re    (len_re),
        .i_raddr (r_idx[FIDX_W-1:0]),
        .o_rdata (len_rdata)
    );

    dtd_ram #(
        .WIDTH (8),
        .DEPTH (BYTE_DEPTH)
    ) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_waddr (byte_waddr),
        .i_wdata (i_entry_byte),
        .i_re    (issue),
        .i_raddr (r_baddr),
        .o_rdata (byte_rdata)
    );

    // Configuration
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODEL_HASH) ? r_hash : '0;

    // Index of the last index byte, right-aligned by group size
    always_comb begin
        shifted_acc = {i_stream_byte, r_acc[31:8]};
        if (r_phase == PH_IDX1) begin
            shifted_acc = {24'd0, i_stream_byte};
        end else if (r_phase == PH_IDX2) begin
            shifted_acc = {16'd0, i_stream_byte, r_acc[31:24]};
        end
    end

    always_comb begin
        start_exp = 1'b0;
        unique case (r_phase)
            PH_TOKEN: begin
                start_exp = i_stream_byte[7] && (i_stream_byte < TOK_IDX1);
            end
            PH_IDX1: begin
                start_exp = 1'b1;
            end
            PH_IDX2: begin
                start_exp = r_count == 7'd1;
            end
            PH_IDX4: begin
                start_exp = r_count == 7'd3;
            end
            default: begin
                start_exp = 1'b0;
            end
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            SQ_CLEAR: begin
                if (r_clr == FIDX_W'(FRAG_DEPTH - 1)) begin
                    n_seq = SQ_IDLE;
                end
            end
            SQ_IDLE: begin
                if (stream_go && start_exp) begin
                    n_seq = SQ_CHECK;
                end
            end
            SQ_CHECK: begin
                if (!range_err) begin
                    n_seq = SQ_LEN;
                end else if (out_free) begin
                    n_seq = SQ_IDLE;
                end
            end
            SQ_LEN: begin
                n_seq = SQ_EXP;
            end
            SQ_EXP: begin
                if ((r_remaining == '0) && !r_pend) begin
                    n_seq = SQ_IDLE;
                end
            end
            default: begin
                n_seq = SQ_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_phase      = r_phase;
        n_count      = r_count;
        n_acc        = r_acc;
        n_halted     = r_halted;
        n_idx        = r_idx;
        n_store      = r_store;
        n_baddr      = r_baddr;
        n_remaining  = r_remaining;
        n_pend       = r_pend;
        n_pend_last  = r_pend_last;
        n_clr        = r_clr;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;

        unique case (r_seq)
            SQ_CLEAR: begin
                n_clr = r_clr + FIDX_W'(1);
            end
            SQ_IDLE: begin
                if (stream_go) begin
                    unique case (r_phase)
                        PH_HASH: begin
                            n_acc   = {i_stream_byte, r_acc[31:8]};
                            n_count = r_count + 7'd1;
                            if (n_count == HASH_BYTES) begin
                                n_count = '0;
                                n_phase = PH_TOKEN;
                                if (n_acc != r_hash) begin
                                    n_halted     = 1'b1;
                                    n_out_valid  = 1'b1;
                                    n_out_byte   = '0;
                                    n_out_last   = 1'b1;
                                    n_out_status = STAT_HASH;
                                end
                            end
                        end
                        PH_LITERAL: begin
                            n_out_valid  = 1'b1;
                            n_out_byte   = i_stream_byte;
                            n_out_last   = 1'b1;
                            n_out_status = STAT_DATA;
                            n_count      = r_count - 7'd1;
                            if (n_count == '0) begin
                                n_phase = PH_TOKEN;
                            end
                        end
                        PH_IDX1, PH_IDX2, PH_IDX4: begin
                            n_acc   = {i_stream_byte, r_acc[31:8]};
                            n_count = r_count + 7'd1;
                            if (start_exp) begin
                                n_count = '0;
                                n_phase = PH_TOKEN;
                                n_idx   = shifted_acc;
                            end
                        end
                        default: begin
                            n_phase = PH_TOKEN;
                            if (!i_stream_byte[7]) begin
                                if (i_stream_byte != 8'd0) begin
                                    n_count = i_stream_byte[6:0];
                                    n_phase = PH_LITERAL;
                                end
                            end else if (start_exp) begin
                                n_idx = {25'd0, i_stream_byte[6:0]};
                            end else if (i_stream_byte == TOK_IDX3) begin
                                n_halted     = 1'b1;
                                n_out_valid  = 1'b1;
                                n_out_byte   = '0;
                                n_out_last   = 1'b1;
                                n_out_status = STAT_THREE;
                            end else begin
                                n_acc   = '0;
                                n_count = '0;
                                if (i_stream_byte == TOK_IDX1) begin
                                    n_phase = PH_IDX1;
                                end else if (i_stream_byte == TOK_IDX2) begin
                                    n_phase = PH_IDX2;
                                end else begin
                                    n_phase = PH_IDX4;
                                end
                            end
                        end
                    endcase
                end
            end
            SQ_CHECK: begin
                n_store = r_idx < 32'(FRAG_DEPTH);
                if (range_err && out_free) begin
                    n_halted     = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_byte   = '0;
                    n_out_last   = 1'b1;
                    n_out_status = STAT_RANGE;
                end
            end
            SQ_LEN: begin
                n_remaining = r_store ? len_rdata : '0;
                n_baddr = BADDR_W'(32'(r_idx[FIDX_W-1:0]) * 32'(MAX_FRAGMENT_LEN));
            end
            SQ_EXP: begin
                if (move) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = byte_rdata;
                    n_out_last   = r_pend_last;
                    n_out_status = STAT_DATA;
                    n_pend       = 1'b0;
                end
                if (issue) begin
                    n_pend      = 1'b1;
                    n_pend_last = r_remaining == LEN_W'(1);
                    n_remaining = r_remaining - LEN_W'(1);
                    n_baddr     = r_baddr + BADDR_W'(1);
                end
            end
            default: begin
                n_pend = r_pend;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SQ_CLEAR;
            r_phase     <= PH_HASH;
            r_count     <= '0;
            r_acc       <= '0;
            r_halted    <= 1'b0;
            r_hash      <= '0;
            r_out_valid <= 1'b0;
            r_remaining <= '0;
            r_pend      <= 1'b0;
            r_clr       <= '0;
        end else begin
            r_seq       <= n_seq;
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_acc       <= n_acc;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
            r_remaining <= n_remaining;
            r_pend      <= n_pend;
            r_clr       <= n_clr;
            if (cfg_wr && (paddr[2] == REG_MODEL_HASH)) begin
                r_hash <= pwdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
        r_idx        <= n_idx;
        r_store      <= n_store;
        r_baddr      <= n_baddr;
        r_pend_last  <= n_pend_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_out_last;
    assign o_status    = r_out_status;

    // Checks
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag cleared without reset");

    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != STAT_DATA)) |-> r_halted)
        else $error("error transfer without halt");

    a_halt_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_halted) |-> (r_out_valid && (r_out_status != STAT_DATA) && r_out_last))
        else $error("halt without error transfer");

    a_exp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq != SQ_EXP) |-> ((r_remaining == '0) && !r_pend))
        else $error("expansion work left outside expansion");

    a_hash_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HASH) |-> (r_count < HASH_BYTES))
        else $error("header byte count overran");

endmodule

`default_nettype wire
